@@ src/gregorian_julian_date_converter_macros.svh @@
// Assertion macros for the Gregorian/Julian date converter.
// Included by the modules that check their own control logic; no other dependencies.
`ifndef GREGORIAN_JULIAN_DATE_CONVERTER_MACROS_SVH
`define GREGORIAN_JULIAN_DATE_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GJDC_ASSERT_IMP(name, clk_sig, rst_sig, ante, cons, msg) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GJDC_ASSERT_NXT(name, clk_sig, rst_sig, ante, cons, msg) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/gjdc_pkg.sv @@
// Shared types, constants and tables for the Gregorian/Julian date converter.
// No dependencies; used by every module of the block.
package gjdc_pkg;

	typedef logic [13:0] year_t;
	typedef logic [3:0]  month_t;
	typedef logic [4:0]  mday_t;
	typedef logic [4:0]  hour_t;
	typedef logic [5:0]  minute_t;
	typedef logic [5:0]  second_t;
	typedef logic [22:0] dnum_t;
	typedef logic [16:0] nsec_t;

	localparam logic OP_CAL2JD = 1'b0;
	localparam logic OP_JD2CAL = 1'b1;

	localparam dnum_t JD_OFFSET   = 23'd1721119;
	localparam dnum_t SPAN_LO_DAY = 23'd1721425;
	localparam dnum_t SPAN_HI_DAY = 23'd5373484;
	localparam nsec_t HALF_DAY     = 17'd43200;
	localparam nsec_t DAY_SECS     = 17'd86400;
	localparam nsec_t SEC_PER_HOUR = 17'd3600;
	localparam nsec_t SEC_PER_MIN  = 17'd60;
	localparam year_t MAX_YEAR     = 14'd9999;

	localparam logic [17:0] DAYS_400Y = 18'd146097;
	localparam logic [10:0] DAYS_4Y   = 11'd1461;
	localparam logic [7:0]  DAYS_5MO  = 8'd153;

	// Reciprocals for exact division by constants over the ranges in use:
	// floor(x / d) == (x * RECIP) >> shift.
	localparam logic [12:0] RECIP_100    = 13'd5243;     // shift 19
	localparam logic [23:0] RECIP_146097 = 24'd15051803; // shift 41
	localparam logic [19:0] RECIP_1461   = 20'd734937;   // shift 30
	localparam logic [15:0] RECIP_3600   = 16'd37283;    // shift 27
	localparam logic [12:0] RECIP_60     = 13'd4370;     // shift 18
	localparam logic [12:0] RECIP_153    = 13'd6854;     // shift 20
	localparam logic [7:0]  RECIP_5      = 8'd205;       // shift 10

	typedef struct packed {
		logic vld;
		logic op;
	} stage_ctl_t;

	typedef struct packed {
		dnum_t day_number;
		nsec_t noon_seconds;
		logic  range_error;
	} jd_res_t;

	typedef struct packed {
		year_t   year;
		month_t  month;
		mday_t   day;
		hour_t   hour;
		minute_t minute;
		second_t second;
		logic    range_error;
	} cal_res_t;

	typedef struct packed {
		year_t   year;
		month_t  month;
		mday_t   day;
		hour_t   hour;
		minute_t minute;
		second_t second;
		dnum_t   day_number;
		nsec_t   noon_seconds;
		logic    range_error;
	} res_t;

	// Days before the shifted month (March is month 0): (153 * m + 2) / 5.
	function automatic logic [8:0] month_offset(input logic [3:0] m);
		case (m)
			4'd0:    month_offset = 9'd0;
			4'd1:    month_offset = 9'd31;
			4'd2:    month_offset = 9'd61;
			4'd3:    month_offset = 9'd92;
			4'd4:    month_offset = 9'd122;
			4'd5:    month_offset = 9'd153;
			4'd6:    month_offset = 9'd184;
			4'd7:    month_offset = 9'd214;
			4'd8:    month_offset = 9'd245;
			4'd9:    month_offset = 9'd275;
			4'd10:   month_offset = 9'd306;
			4'd11:   month_offset = 9'd337;
			4'd12:   month_offset = 9'd367;
			default: month_offset = 9'd0;
		endcase
	endfunction

endpackage

@@ src/gjdc_cal2jd.sv @@
// Calendar date and time to Julian day number and seconds since noon.
// Seven register stages advancing on en; depends on gjdc_pkg.
module gjdc_cal2jd (
	input  logic              clk,
	input  logic              en,
	input  gjdc_pkg::year_t   year,
	input  gjdc_pkg::month_t  month,
	input  gjdc_pkg::mday_t   day,
	input  gjdc_pkg::hour_t   hour,
	input  gjdc_pkg::minute_t minute,
	input  gjdc_pkg::second_t second,
	output gjdc_pkg::jd_res_t res
);

	// stage 1: flags, shifted month/year, seconds of day
	logic              all_zero, year_bad, late_month;
	logic [3:0]        m_c;
	gjdc_pkg::year_t   y_c;
	gjdc_pkg::nsec_t   secs_c;

	logic              zero_s1, bad_s1;
	logic [3:0]        m_s1;
	gjdc_pkg::year_t   y_s1;
	gjdc_pkg::nsec_t   secs_s1;
	gjdc_pkg::mday_t   day_s1;

	// stage 2
	logic              early;
	logic              zero_s2, bad_s2, dec_s2;
	logic [26:0]       pc_s2;
	gjdc_pkg::year_t   y_s2;
	gjdc_pkg::nsec_t   sa_s2;
	logic [8:0]        mt_s2;
	gjdc_pkg::mday_t   day_s2;

	// stage 3
	logic [6:0]        c_c;
	logic              zero_s3, bad_s3, dec_s3;
	logic [6:0]        c_s3, ya_s3;
	gjdc_pkg::nsec_t   sa_s3;
	logic [8:0]        mt_s3;
	gjdc_pkg::mday_t   day_s3;

	// stage 4
	logic [23:0]       p400_c;
	logic [17:0]       p4_c;
	logic              zero_s4, bad_s4, dec_s4;
	logic [21:0]       t1_s4;
	logic [15:0]       t2_s4;
	gjdc_pkg::nsec_t   sa_s4;
	logic [8:0]        mt_s4;
	gjdc_pkg::mday_t   day_s4;

	// stage 5..7
	logic              zero_s5, bad_s5;
	gjdc_pkg::dnum_t   a_s5, b_s5;
	gjdc_pkg::nsec_t   sa_s5;
	logic              zero_s6, bad_s6;
	gjdc_pkg::dnum_t   j_s6;
	gjdc_pkg::nsec_t   sa_s6;
	logic              in_span, kill;
	gjdc_pkg::jd_res_t res_s7;

	always_comb begin
		all_zero = (year == '0) && (month == '0) && (day == '0) && (hour == '0) &&
			(minute == '0) && (second == '0);
		year_bad = (year == '0) || (year > gjdc_pkg::MAX_YEAR);
		late_month = (month > 4'd2);
		// year starts in March
		m_c = late_month ? month - 4'd3 : month + 4'd9;
		y_c = late_month ? year : year - 14'd1;
		secs_c = 17'(hour) * gjdc_pkg::SEC_PER_HOUR + 17'(minute) * gjdc_pkg::SEC_PER_MIN +
			17'(second);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= all_zero;
			bad_s1  <= year_bad;
			m_s1    <= m_c;
			y_s1    <= y_c;
			secs_s1 <= secs_c;
			day_s1  <= day;
		end
	end

	assign early = (secs_s1 < gjdc_pkg::HALF_DAY);

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= zero_s1;
			bad_s2  <= bad_s1;
			pc_s2   <= 27'(y_s1) * 27'(gjdc_pkg::RECIP_100);
			y_s2    <= y_s1;
			// roll the day at noon: morning belongs to the previous day number
			sa_s2   <= early ? secs_s1 + gjdc_pkg::HALF_DAY : secs_s1 - gjdc_pkg::HALF_DAY;
			dec_s2  <= early;
			mt_s2   <= gjdc_pkg::month_offset(m_s1);
			day_s2  <= day_s1;
		end
	end

	assign c_c = pc_s2[25:19];

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s3 <= zero_s2;
			bad_s3  <= bad_s2;
			dec_s3  <= dec_s2;
			c_s3    <= c_c;
			ya_s3   <= 7'(y_s2 - 14'(c_c) * 14'd100);
			sa_s3   <= sa_s2;
			mt_s3   <= mt_s2;
			day_s3  <= day_s2;
		end
	end

	assign p400_c = 24'(c_s3) * 24'(gjdc_pkg::DAYS_400Y);
	assign p4_c   = 18'(ya_s3) * 18'(gjdc_pkg::DAYS_4Y);

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= zero_s3;
			bad_s4  <= bad_s3;
			dec_s4  <= dec_s3;
			t1_s4   <= p400_c[23:2];
			t2_s4   <= p4_c[17:2];
			sa_s4   <= sa_s3;
			mt_s4   <= mt_s3;
			day_s4  <= day_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s5 <= zero_s4;
			bad_s5  <= bad_s4;
			a_s5    <= 23'(t1_s4) + 23'(t2_s4);
			b_s5    <= 23'(mt_s4) + 23'(day_s4) + gjdc_pkg::JD_OFFSET - 23'(dec_s4);
			sa_s5   <= sa_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s6 <= zero_s5;
			bad_s6  <= bad_s5;
			j_s6    <= a_s5 + b_s5;
			sa_s6   <= sa_s5;
		end
	end

	// seconds since noon stay below a day, so compare day number first
	always_comb begin
		in_span = ((j_s6 > gjdc_pkg::SPAN_LO_DAY) ||
			((j_s6 == gjdc_pkg::SPAN_LO_DAY) && (sa_s6 >= gjdc_pkg::HALF_DAY))) &&
			((j_s6 < gjdc_pkg::SPAN_HI_DAY) ||
			((j_s6 == gjdc_pkg::SPAN_HI_DAY) && (sa_s6 < gjdc_pkg::HALF_DAY)));
		kill = zero_s6 || bad_s6 || !in_span;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s7.day_number   <= kill ? '0 : j_s6;
			res_s7.noon_seconds <= kill ? '0 : sa_s6;
			res_s7.range_error  <= !zero_s6 && (bad_s6 || !in_span);
		end
	end

	assign res = res_s7;

endmodule

@@ src/gjdc_jd2cal.sv @@
// Julian day number and seconds since noon to calendar date and time.
// Seven register stages advancing on en; depends on gjdc_pkg.
module gjdc_jd2cal (
	input  logic               clk,
	input  logic               en,
	input  gjdc_pkg::dnum_t    day_number,
	input  gjdc_pkg::nsec_t    noon_seconds,
	output gjdc_pkg::cal_res_t res
);

	logic              all_zero, late, out_span;
	gjdc_pkg::dnum_t   jj_c;

	logic              zero_s1, bad_s1;
	logic [23:0]       x_s1;
	gjdc_pkg::nsec_t   s_s1;

	logic              zero_s2, bad_s2;
	logic [47:0]       py_s2;
	logic [32:0]       ph_s2;
	logic [23:0]       x_s2;
	gjdc_pkg::nsec_t   s_s2;

	logic [6:0]        yc_c;
	logic [23:0]       j2_c;
	gjdc_pkg::hour_t   hr_c;
	logic              zero_s3, bad_s3;
	logic [6:0]        yc_s3;
	logic [17:0]       w_s3;
	gjdc_pkg::hour_t   hour_s3;
	logic [11:0]       rem_s3;

	logic              zero_s4, bad_s4;
	logic [37:0]       pq_s4;
	logic [24:0]       pm_s4;
	logic [17:0]       w_s4;
	logic [6:0]        yc_s4;
	gjdc_pkg::hour_t   hour_s4;
	logic [11:0]       rem_s4;

	logic [6:0]        q_c;
	logic [10:0]       d3_c;
	logic [8:0]        d4_c;
	gjdc_pkg::minute_t mi_c;
	logic              zero_s5, bad_s5;
	gjdc_pkg::year_t   y_s5;
	logic [10:0]       v_s5;
	gjdc_pkg::hour_t   hour_s5;
	gjdc_pkg::minute_t min_s5;
	gjdc_pkg::second_t sec_s5;

	logic              zero_s6, bad_s6;
	logic [23:0]       pmo_s6;
	logic [10:0]       v_s6;
	gjdc_pkg::year_t   y_s6;
	gjdc_pkg::hour_t   hour_s6;
	gjdc_pkg::minute_t min_s6;
	gjdc_pkg::second_t sec_s6;

	logic [3:0]        mo_c;
	logic [7:0]        d5_c;
	logic [15:0]       pd_c;
	logic              kill;
	gjdc_pkg::cal_res_t res_s7;

	always_comb begin
		all_zero = (day_number == '0) && (noon_seconds == '0);
		late = (noon_seconds >= gjdc_pkg::HALF_DAY);
		out_span = (noon_seconds >= gjdc_pkg::DAY_SECS) ||
			(day_number < gjdc_pkg::SPAN_LO_DAY) ||
			((day_number == gjdc_pkg::SPAN_LO_DAY) && !late) ||
			(day_number > gjdc_pkg::SPAN_HI_DAY) ||
			((day_number == gjdc_pkg::SPAN_HI_DAY) && late);
		// afternoon rolls into the next civil day
		jj_c = day_number + 23'(late) - gjdc_pkg::JD_OFFSET;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= all_zero;
			bad_s1  <= out_span;
			x_s1    <= {jj_c[21:0], 2'b00} - 24'd1;
			s_s1    <= late ? noon_seconds - gjdc_pkg::HALF_DAY :
				noon_seconds + gjdc_pkg::HALF_DAY;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= zero_s1;
			bad_s2  <= bad_s1;
			py_s2   <= 48'(x_s1) * 48'(gjdc_pkg::RECIP_146097);
			ph_s2   <= 33'(s_s1) * 33'(gjdc_pkg::RECIP_3600);
			x_s2    <= x_s1;
			s_s2    <= s_s1;
		end
	end

	always_comb begin
		yc_c = py_s2[47:41];
		j2_c = x_s2 - 24'(yc_c) * 24'(gjdc_pkg::DAYS_400Y);
		hr_c = ph_s2[31:27];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s3 <= zero_s2;
			bad_s3  <= bad_s2;
			yc_s3   <= yc_c;
			// 4 * (j / 4) + 3
			w_s3    <= j2_c[17:0] | 18'd3;
			hour_s3 <= hr_c;
			rem_s3  <= 12'(s_s2 - 17'(hr_c) * gjdc_pkg::SEC_PER_HOUR);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= zero_s3;
			bad_s4  <= bad_s3;
			pq_s4   <= 38'(w_s3) * 38'(gjdc_pkg::RECIP_1461);
			pm_s4   <= 25'(rem_s3) * 25'(gjdc_pkg::RECIP_60);
			w_s4    <= w_s3;
			yc_s4   <= yc_s3;
			hour_s4 <= hour_s3;
			rem_s4  <= rem_s3;
		end
	end

	always_comb begin
		q_c  = pq_s4[36:30];
		d3_c = 11'(w_s4 - 18'(q_c) * 18'(gjdc_pkg::DAYS_4Y));
		d4_c = 9'((12'(d3_c) + 12'd4) >> 2);
		mi_c = pm_s4[23:18];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s5 <= zero_s4;
			bad_s5  <= bad_s4;
			y_s5    <= 14'(yc_s4) * 14'd100 + 14'(q_c);
			v_s5    <= 11'(d4_c) * 11'd5 - 11'd3;
			hour_s5 <= hour_s4;
			min_s5  <= mi_c;
			sec_s5  <= 6'(rem_s4 - 12'(mi_c) * 12'd60);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s6 <= zero_s5;
			bad_s6  <= bad_s5;
			pmo_s6  <= 24'(v_s5) * 24'(gjdc_pkg::RECIP_153);
			v_s6    <= v_s5;
			y_s6    <= y_s5;
			hour_s6 <= hour_s5;
			min_s6  <= min_s5;
			sec_s6  <= sec_s5;
		end
	end

	always_comb begin
		mo_c = pmo_s6[23:20];
		d5_c = 8'(v_s6 - 11'(mo_c) * 11'(gjdc_pkg::DAYS_5MO));
		pd_c = (16'(d5_c) + 16'd5) * 16'(gjdc_pkg::RECIP_5);
		kill = zero_s6 || bad_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// months counted from March; January and February close the year
			if (kill) begin
				res_s7.year  <= '0;
				res_s7.month <= '0;
			end else if (mo_c < 4'd10) begin
				res_s7.year  <= y_s6;
				res_s7.month <= mo_c + 4'd3;
			end else begin
				res_s7.year  <= y_s6 + 14'd1;
				res_s7.month <= mo_c - 4'd9;
			end
			res_s7.day         <= kill ? '0 : pd_c[14:10];
			res_s7.hour        <= kill ? '0 : hour_s6;
			res_s7.minute      <= kill ? '0 : min_s6;
			res_s7.second      <= kill ? '0 : sec_s6;
			res_s7.range_error <= !zero_s6 && bad_s6;
		end
	end

	assign res = res_s7;

endmodule

@@ src/gjdc_outbuf.sv @@
// Output register plus skid entry that decouples the pipeline from the result channel.
// Depends on gjdc_pkg and the assertion macro header.
`include "gregorian_julian_date_converter_macros.svh"

module gjdc_outbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gjdc_pkg::res_t push_data,
	output logic           pipe_en,
	output logic           out_valid,
	input  logic           out_ready,
	output gjdc_pkg::res_t out_data
);

	logic           out_v_q, skid_v_q;
	gjdc_pkg::res_t out_d_q, skid_d_q;
	logic           pop;

	assign pop     = out_v_q && out_ready;
	// hold the pipeline only once the skid entry is taken
	assign pipe_en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_d_q <= skid_d_q;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				skid_d_q <= push_data;
			end else begin
				out_d_q <= push_data;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_d_q;

	`GJDC_ASSERT_IMP(a_skid_needs_out, clk, arst_n, skid_v_q, out_v_q, "skid full with output empty")
	`GJDC_ASSERT_IMP(a_no_push_when_full, clk, arst_n, push, !skid_v_q, "push into full buffer")
	`GJDC_ASSERT_NXT(a_push_lands, clk, arst_n, push, out_v_q, "pushed request not held")
	`GJDC_ASSERT_NXT(a_skid_drains, clk, arst_n, skid_v_q && out_ready, out_v_q && !skid_v_q, "skid not drained")

endmodule

@@ src/gregorian_julian_date_converter.sv @@
// Channel   Handshake              Payload
// request   in_valid / in_ready    op, in_year .. in_second, in_day_number, in_noon_seconds
// result    out_valid / out_ready  out_year .. out_second, out_day_number, out_noon_seconds,
//                                  range_error
//
// One request per clock while the skid entry is empty; a result passes through seven pipeline
// stages, both directions computed side by side, then the output register.
// arst_n clears the stage valid bits and the output buffer; no clearing pass is needed.
// A stalled result fills the skid entry, which freezes the pipeline and drops in_ready
// (a registered signal) until the skid entry is drained.
// Depends on gjdc_pkg, gjdc_cal2jd, gjdc_jd2cal, gjdc_outbuf and the macro header.
`include "gregorian_julian_date_converter_macros.svh"

module gregorian_julian_date_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	input  gjdc_pkg::year_t   in_year,
	input  gjdc_pkg::month_t  in_month,
	input  gjdc_pkg::mday_t   in_day,
	input  gjdc_pkg::hour_t   in_hour,
	input  gjdc_pkg::minute_t in_minute,
	input  gjdc_pkg::second_t in_second,
	input  gjdc_pkg::dnum_t   in_day_number,
	input  gjdc_pkg::nsec_t   in_noon_seconds,
	output logic              out_valid,
	input  logic              out_ready,
	output gjdc_pkg::year_t   out_year,
	output gjdc_pkg::month_t  out_month,
	output gjdc_pkg::mday_t   out_day,
	output gjdc_pkg::hour_t   out_hour,
	output gjdc_pkg::minute_t out_minute,
	output gjdc_pkg::second_t out_second,
	output gjdc_pkg::dnum_t   out_day_number,
	output gjdc_pkg::nsec_t   out_noon_seconds,
	output logic              range_error
);

	logic                 en;
	gjdc_pkg::stage_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	gjdc_pkg::jd_res_t    jd_res;
	gjdc_pkg::cal_res_t   cal_res;
	gjdc_pkg::res_t       res_c, out_d;
	logic                 fields_set;

	gjdc_cal2jd u_cal2jd (
		.clk    (clk),
		.en     (en),
		.year   (in_year),
		.month  (in_month),
		.day    (in_day),
		.hour   (in_hour),
		.minute (in_minute),
		.second (in_second),
		.res    (jd_res)
	);

	gjdc_jd2cal u_jd2cal (
		.clk          (clk),
		.en           (en),
		.day_number   (in_day_number),
		.noon_seconds (in_noon_seconds),
		.res          (cal_res)
	);

	// valid and direction travel alongside the datapath stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s1.vld <= in_valid;
			ctl_s1.op  <= op;
			ctl_s2     <= ctl_s1;
			ctl_s3     <= ctl_s2;
			ctl_s4     <= ctl_s3;
			ctl_s5     <= ctl_s4;
			ctl_s6     <= ctl_s5;
			ctl_s7     <= ctl_s6;
		end
	end

	always_comb begin
		res_c = '0;
		if (ctl_s7.op == gjdc_pkg::OP_JD2CAL) begin
			res_c.year        = cal_res.year;
			res_c.month       = cal_res.month;
			res_c.day         = cal_res.day;
			res_c.hour        = cal_res.hour;
			res_c.minute      = cal_res.minute;
			res_c.second      = cal_res.second;
			res_c.range_error = cal_res.range_error;
		end else begin
			res_c.day_number   = jd_res.day_number;
			res_c.noon_seconds = jd_res.noon_seconds;
			res_c.range_error  = jd_res.range_error;
		end
	end

	gjdc_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && ctl_s7.vld),
		.push_data (res_c),
		.pipe_en   (en),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_d)
	);

	assign in_ready         = en;
	assign out_year         = out_d.year;
	assign out_month        = out_d.month;
	assign out_day          = out_d.day;
	assign out_hour         = out_d.hour;
	assign out_minute       = out_d.minute;
	assign out_second       = out_d.second;
	assign out_day_number   = out_d.day_number;
	assign out_noon_seconds = out_d.noon_seconds;
	assign range_error      = out_d.range_error;

	assign fields_set = |{out_year, out_month, out_day, out_hour, out_minute, out_second,
		out_day_number, out_noon_seconds};

	`GJDC_ASSERT_IMP(a_err_clears_fields, clk, arst_n, out_valid && range_error, !fields_set, "error result carries data")

endmodule

@@ dv/gjdc_checker.sv @@
// Result checker for the Gregorian/Julian date converter: predicts each accepted request
// and compares every accepted result, in order, against the oldest prediction.
// Depends on gjdc_pkg for field types, result struct and constants.
module gjdc_checker
	import gjdc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_ready,
	input  logic    op,
	input  year_t   in_year,
	input  month_t  in_month,
	input  mday_t   in_day,
	input  hour_t   in_hour,
	input  minute_t in_minute,
	input  second_t in_second,
	input  dnum_t   in_day_number,
	input  nsec_t   in_noon_seconds,
	input  logic    out_valid,
	input  logic    out_ready,
	input  year_t   out_year,
	input  month_t  out_month,
	input  mday_t   out_day,
	input  hour_t   out_hour,
	input  minute_t out_minute,
	input  second_t out_second,
	input  dnum_t   out_day_number,
	input  nsec_t   out_noon_seconds,
	input  logic    range_error,
	output int      mismatches,
	output int      outstanding
);

	localparam int REPORT_LIMIT = 10;
	localparam longint unsigned SPAN_FIRST =
		64'(SPAN_LO_DAY) * 64'(DAY_SECS) + 64'(HALF_DAY);
	localparam longint unsigned SPAN_LAST =
		64'(SPAN_HI_DAY) * 64'(DAY_SECS) + 64'(HALF_DAY) - 64'd1;

	res_t expected_dates[$];
	int   error_count = 0;

	function automatic res_t date_convert(input logic op_i, input year_t yr, input month_t mo,
		input mday_t dy, input hour_t hh, input minute_t mi, input second_t ss,
		input dnum_t dn, input nsec_t ns);
		longint unsigned y, m, d, c, ya, j, s, t, q, hr, mn, sc;
		res_t r;
		r = '0;
		if (op_i == OP_CAL2JD) begin
			if ((yr | mo | dy | hh | mi | ss) == 0)
				return r;
			if (yr == 0 || yr > MAX_YEAR) begin
				r.range_error = 1'b1;
				return r;
			end
			// shift the year so that it starts in March
			if (mo > 2) begin
				m = 64'(mo) - 3;
				y = 64'(yr);
			end else begin
				m = 64'(mo) + 9;
				y = 64'(yr) - 1;
			end
			c = y / 100;
			ya = y - 100 * c;
			j = (146097 * c) / 4 + (1461 * ya) / 4 + (153 * m + 2) / 5 + 64'(dy)
				+ 64'(JD_OFFSET);
			s = 64'(hh) * 3600 + 64'(mi) * 60 + 64'(ss);
			// the Julian day turns over at noon
			if (s < 64'(HALF_DAY)) begin
				j = j - 1;
				s = s + 64'(HALF_DAY);
			end else begin
				s = s - 64'(HALF_DAY);
			end
			t = j * 64'(DAY_SECS) + s;
			if (t < SPAN_FIRST || t > SPAN_LAST) begin
				r.range_error = 1'b1;
				return r;
			end
			r.day_number = j[22:0];
			r.noon_seconds = s[16:0];
		end else begin
			if (dn == 0 && ns == 0)
				return r;
			t = 64'(dn) * 64'(DAY_SECS) + 64'(ns);
			if (ns >= DAY_SECS || t < SPAN_FIRST || t > SPAN_LAST) begin
				r.range_error = 1'b1;
				return r;
			end
			j = 64'(dn);
			if (ns >= HALF_DAY) begin
				s = 64'(ns) - 64'(HALF_DAY);
				j = j + 1;
			end else begin
				s = 64'(ns) + 64'(HALF_DAY);
			end
			j = j - 64'(JD_OFFSET);
			y = (4 * j - 1) / 146097;
			j = 4 * j - 1 - 146097 * y;
			d = j / 4;
			q = (4 * d + 3) / 1461;
			d = 4 * d + 3 - 1461 * q;
			d = (d + 4) / 4;
			m = (5 * d - 3) / 153;
			d = 5 * d - 3 - 153 * m;
			d = (d + 5) / 5;
			y = 100 * y + q;
			if (m < 10) begin
				m = m + 3;
			end else begin
				m = m - 9;
				y = y + 1;
			end
			hr = s / 3600;
			mn = (s % 3600) / 60;
			sc = s % 60;
			r.year = y[13:0];
			r.month = m[3:0];
			r.day = d[4:0];
			r.hour = hr[4:0];
			r.minute = mn[5:0];
			r.second = sc[5:0];
		end
		return r;
	endfunction

	always @(posedge clk) begin
		res_t got, want;
		if (arst_n) begin
			// compare before taking the new request so a result never matches its own cycle
			if (out_valid && out_ready) begin
				got.year = out_year;
				got.month = out_month;
				got.day = out_day;
				got.hour = out_hour;
				got.minute = out_minute;
				got.second = out_second;
				got.day_number = out_day_number;
				got.noon_seconds = out_noon_seconds;
				got.range_error = range_error;
				if (expected_dates.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("unexpected result at %0t: %0d-%0d-%0d %0d:%0d:%0d jd %0d+%0d err %0b",
							$realtime, got.year, got.month, got.day, got.hour, got.minute,
							got.second, got.day_number, got.noon_seconds, got.range_error);
				end else begin
					want = expected_dates.pop_front();
					if (got.year !== want.year || got.month !== want.month
						|| got.day !== want.day || got.hour !== want.hour
						|| got.minute !== want.minute || got.second !== want.second
						|| got.day_number !== want.day_number
						|| got.noon_seconds !== want.noon_seconds
						|| got.range_error !== want.range_error) begin
						error_count++;
						if (error_count <= REPORT_LIMIT)
							$display({"mismatch at %0t: expected %0d-%0d-%0d %0d:%0d:%0d jd %0d+%0d ",
								"err %0b, got %0d-%0d-%0d %0d:%0d:%0d jd %0d+%0d err %0b"},
								$realtime, want.year, want.month, want.day, want.hour,
								want.minute, want.second, want.day_number, want.noon_seconds,
								want.range_error, got.year, got.month, got.day, got.hour,
								got.minute, got.second, got.day_number, got.noon_seconds,
								got.range_error);
					end
				end
			end
			if (in_valid && in_ready)
				expected_dates.push_back(date_convert(op, in_year, in_month, in_day, in_hour,
					in_minute, in_second, in_day_number, in_noon_seconds));
			mismatches <= error_count;
			outstanding <= expected_dates.size();
		end
	end

endmodule

@@ dv/tb_top.sv @@
// Top of the date converter testbench: clock, reset, request and result stimulus with
// random idling, a stall watchdog and the verdict.
// Depends on gjdc_pkg, gregorian_julian_date_converter and gjdc_checker.
module tb_top;
	import gjdc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	logic    op;
	year_t   in_year;
	month_t  in_month;
	mday_t   in_day;
	hour_t   in_hour;
	minute_t in_minute;
	second_t in_second;
	dnum_t   in_day_number;
	nsec_t   in_noon_seconds;
	logic    out_valid;
	logic    out_ready = 1'b0;
	year_t   out_year;
	month_t  out_month;
	mday_t   out_day;
	hour_t   out_hour;
	minute_t out_minute;
	second_t out_second;
	dnum_t   out_day_number;
	nsec_t   out_noon_seconds;
	logic    range_error;

	int mismatches;
	int outstanding;
	int send_idle_pct = 31;
	int recv_idle_pct = 54;
	int stall_cycles = 0;

	gregorian_julian_date_converter uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.in_year(in_year), .in_month(in_month), .in_day(in_day),
		.in_hour(in_hour), .in_minute(in_minute), .in_second(in_second),
		.in_day_number(in_day_number), .in_noon_seconds(in_noon_seconds),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_year(out_year), .out_month(out_month), .out_day(out_day),
		.out_hour(out_hour), .out_minute(out_minute), .out_second(out_second),
		.out_day_number(out_day_number), .out_noon_seconds(out_noon_seconds),
		.range_error(range_error)
	);

	gjdc_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.in_year(in_year), .in_month(in_month), .in_day(in_day),
		.in_hour(in_hour), .in_minute(in_minute), .in_second(in_second),
		.in_day_number(in_day_number), .in_noon_seconds(in_noon_seconds),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_year(out_year), .out_month(out_month), .out_day(out_day),
		.out_hour(out_hour), .out_minute(out_minute), .out_second(out_second),
		.out_day_number(out_day_number), .out_noon_seconds(out_noon_seconds),
		.range_error(range_error),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_request(input logic o, input year_t yr, input month_t mo,
		input mday_t dy, input hour_t hh, input minute_t mi, input second_t ss,
		input dnum_t dn, input nsec_t ns);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		in_year <= yr;
		in_month <= mo;
		in_day <= dy;
		in_hour <= hh;
		in_minute <= mi;
		in_second <= ss;
		in_day_number <= dn;
		in_noon_seconds <= ns;
		// hold the request until it is taken
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_results;
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic send_random(input int count);
		int      sel;
		int      month_len;
		logic    o;
		year_t   yr;
		month_t  mo;
		mday_t   dy;
		hour_t   hh;
		minute_t mi;
		second_t ss;
		dnum_t   dn;
		nsec_t   ns;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			// fields the operation ignores carry random bits
			yr = $urandom_range(16383, 0);
			mo = $urandom_range(15, 0);
			dy = $urandom_range(31, 0);
			hh = $urandom_range(31, 0);
			mi = $urandom_range(63, 0);
			ss = $urandom_range(63, 0);
			dn = $urandom_range(8388607, 0);
			ns = $urandom_range(131071, 0);
			if (sel < 40) begin
				o = OP_CAL2JD;
				if ($urandom_range(0, 19) == 0)
					yr = $urandom_range(0, 1) ? 14'd1 : MAX_YEAR;
				else
					yr = $urandom_range(1, 9999);
				mo = $urandom_range(1, 12);
				case (mo)
					4'd2:    month_len = ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0)
						? 29 : 28;
					4'd4, 4'd6, 4'd9, 4'd11: month_len = 30;
					default: month_len = 31;
				endcase
				dy = $urandom_range(1, month_len);
				hh = $urandom_range(0, 23);
				mi = $urandom_range(0, 59);
				ss = $urandom_range(0, 59);
			end else if (sel < 80) begin
				o = OP_JD2CAL;
				if ($urandom_range(0, 19) == 0)
					dn = $urandom_range(0, 1) ? SPAN_LO_DAY : SPAN_HI_DAY;
				else
					dn = $urandom_range(SPAN_LO_DAY, SPAN_HI_DAY);
				ns = $urandom_range(0, 86399);
			end else if (sel < 90) begin
				o = OP_CAL2JD;
			end else begin
				o = OP_JD2CAL;
				// probe the span edges with raw noon seconds
				if ($urandom_range(0, 1))
					dn = ($urandom_range(0, 1) ? SPAN_LO_DAY : SPAN_HI_DAY)
						+ $urandom_range(0, 2) - 1;
			end
			send_request(o, yr, mo, dy, hh, mi, ss, dn, ns);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_CAL2JD;
		in_year <= '0;
		in_month <= '0;
		in_day <= '0;
		in_hour <= '0;
		in_minute <= '0;
		in_second <= '0;
		in_day_number <= '0;
		in_noon_seconds <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// all-zero inputs
		send_request(OP_CAL2JD, 0, 0, 0, 0, 0, 0, 0, 0);
		send_request(OP_JD2CAL, 0, 0, 0, 0, 0, 0, 0, 0);
		// span edges and year out of range
		send_request(OP_CAL2JD, 1, 1, 1, 0, 0, 0, 0, 0);
		send_request(OP_CAL2JD, 1, 1, 0, 23, 59, 59, 0, 0);
		send_request(OP_CAL2JD, 9999, 12, 31, 23, 59, 59, 0, 0);
		send_request(OP_CAL2JD, 9999, 12, 32, 0, 0, 0, 0, 0);
		send_request(OP_CAL2JD, 0, 1, 1, 0, 0, 0, 0, 0);
		send_request(OP_CAL2JD, 0, 0, 0, 0, 0, 1, 0, 0);
		send_request(OP_CAL2JD, 10000, 1, 1, 0, 0, 0, 0, 0);
		send_request(OP_CAL2JD, 16383, 15, 31, 31, 63, 63, 0, 0);
		// odd calendar fields, leap day and the noon rollover
		send_request(OP_CAL2JD, 2024, 0, 15, 12, 0, 0, 0, 0);
		send_request(OP_CAL2JD, 2024, 13, 1, 6, 30, 0, 0, 0);
		send_request(OP_CAL2JD, 2023, 2, 31, 0, 0, 0, 0, 0);
		send_request(OP_CAL2JD, 2000, 2, 29, 11, 59, 59, 0, 0);
		send_request(OP_CAL2JD, 2000, 2, 29, 12, 0, 0, 0, 0);
		send_request(OP_CAL2JD, 1999, 12, 31, 31, 63, 63, 0, 0);
		// Julian span edges and bad noon seconds
		send_request(OP_JD2CAL, 0, 0, 0, 0, 0, 0, SPAN_LO_DAY, HALF_DAY);
		send_request(OP_JD2CAL, 0, 0, 0, 0, 0, 0, SPAN_LO_DAY, HALF_DAY - 1);
		send_request(OP_JD2CAL, 0, 0, 0, 0, 0, 0, SPAN_HI_DAY, HALF_DAY - 1);
		send_request(OP_JD2CAL, 0, 0, 0, 0, 0, 0, SPAN_HI_DAY, HALF_DAY);
		send_request(OP_JD2CAL, 0, 0, 0, 0, 0, 0, 2451545, 0);
		send_request(OP_JD2CAL, 0, 0, 0, 0, 0, 0, 2451545, 86399);
		send_request(OP_JD2CAL, 0, 0, 0, 0, 0, 0, 2451545, DAY_SECS);
		send_request(OP_JD2CAL, 0, 0, 0, 0, 0, 0, 2451545, 131071);
		send_request(OP_JD2CAL, 0, 0, 0, 0, 0, 0, 8388607, 0);
		send_request(OP_JD2CAL, 0, 0, 0, 0, 0, 0, 0, 1);

		send_random(330);
		// hold off new requests until the pipeline has emptied
		wait_results();

		send_idle_pct = 54;
		recv_idle_pct = 31;
		send_random(360);
		wait_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(360);
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
